>>> design/bus_cycle_command_controller_unit_macros.svh
// Assertion macros for the bus cycle command controller checker.
`ifndef BUS_CYCLE_COMMAND_CONTROLLER_UNIT_MACROS_SVH
`define BUS_CYCLE_COMMAND_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BCC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bus cycle controller check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bus cycle controller check failed");

`endif

>>> design/bcc_pkg.sv
package bcc_pkg;

	typedef enum logic [2:0] {
		CK_PASSIVE = 3'd0,
		CK_MEMW    = 3'd1,
		CK_MEMR    = 3'd2,
		CK_FETCH   = 3'd3,
		CK_HALT    = 3'd4,
		CK_IOW     = 3'd5,
		CK_IOR     = 3'd6,
		CK_INTA    = 3'd7
	} ck_t;

	localparam int PB_ALE  = 0;
	localparam int PB_DEN  = 1;
	localparam int PB_DTR  = 2;
	localparam int PB_MEMR = 3;
	localparam int PB_MEMW = 4;
	localparam int PB_IOR  = 5;
	localparam int PB_IOW  = 6;
	localparam int PB_INTA = 7;

	localparam logic [7:0] PIN_STROBES = 8'hF8;
	localparam logic [7:0] PIN_RESET   = 8'hFA;

	localparam logic [1:0] DIR_OFF  = 2'd0;
	localparam logic [1:0] DIR_IN   = 2'd1;
	localparam logic [1:0] DIR_OUT  = 2'd2;

	localparam logic [1:0] RECOVERY_STEPS = 2'd3;

	typedef struct packed {
		ck_t        cycle_kind;
		logic       was_active;
		logic       strobe_held;
		logic       dma_inhibited;
		logic [1:0] recovery_count;
		logic [7:0] pins;
		logic [1:0] ram_dir;
		logic [1:0] data_dir;
	} bcc_state_t;

	typedef struct packed {
		logic [7:0] pins;
		logic [1:0] data_dir;
		logic [1:0] ram_dir;
		logic       latch_release;
		logic       hold_active;
	} bcc_result_t;

	localparam bcc_state_t STATE_RESET = '{
		cycle_kind:     CK_PASSIVE,
		was_active:     1'b0,
		strobe_held:    1'b0,
		dma_inhibited:  1'b0,
		recovery_count: 2'd0,
		pins:           PIN_RESET,
		ram_dir:        DIR_OFF,
		data_dir:       DIR_OFF
	};

	function automatic logic write_kind(input ck_t k);
		return (k == CK_IOW) || (k == CK_MEMW);
	endfunction

	function automatic logic [7:0] strobe_bit(input ck_t k);
		logic [7:0] b;
		b = 8'h00;
		case (k)
			CK_INTA:          b[PB_INTA] = 1'b1;
			CK_IOR:           b[PB_IOR]  = 1'b1;
			CK_IOW:           b[PB_IOW]  = 1'b1;
			CK_FETCH, CK_MEMR: b[PB_MEMR] = 1'b1;
			CK_MEMW:          b[PB_MEMW] = 1'b1;
			default:          b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [1:0] ram_steer(input ck_t k, input logic ram_sel);
		logic [1:0] d;
		d = DIR_OFF;
		if (ram_sel && (k == CK_FETCH || k == CK_MEMR))
			d = DIR_IN;
		else if (ram_sel && k == CK_MEMW)
			d = DIR_OUT;
		return d;
	endfunction

endpackage

>>> design/bus_cycle_command_controller_unit.sv
// Bus cycle command controller, 8288 style, with DMA inhibit and bus recovery.
// Input channel (in_valid/in_ready): one item per bus clock evaluation carrying
// status_n, cmd_enable, wait_n and the two high address bits.
// Output channel (out_valid/out_ready): one item per input item with all pin
// levels, transceiver directions, latch_release and hold_active after it.
// An accepted item goes into the input register; the decode/sequencing logic then
// updates the controller state and the result register at the same edge, and
// out_valid rises with the result register.
// Throughput: one item per cycle while the receiver takes results; the state
// loop closes through the sequencing logic, so items may follow back to back.
// A stalled receiver holds the result register; the input register keeps one
// more item, then in_ready drops until the result is taken.
// Reset clears both valid flags and returns the state to passive: strobes and
// DEN high, ALE and DT/R low, transceivers off, no recovery pending.
module bus_cycle_command_controller_unit
	import bcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] status_n,
	input  logic       cmd_enable,
	input  logic       wait_n,
	input  logic       addr_bit18,
	input  logic       addr_bit19,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       ale,
	output logic       den_n,
	output logic       dt_r,
	output logic       memr_n,
	output logic       memw_n,
	output logic       ior_n,
	output logic       iow_n,
	output logic       inta_n,
	output logic [1:0] data_xcvr_dir,
	output logic [1:0] ram_xcvr_dir,
	output logic       latch_release,
	output logic       hold_active
);

	logic        valid_s1;
	logic [2:0]  status_n_s1;
	logic        cmd_enable_s1;
	logic        wait_n_s1;
	logic        addr_bit18_s1;
	logic        addr_bit19_s1;
	bcc_state_t  state_q;
	bcc_state_t  state_nxt;
	bcc_result_t res_nxt;
	bcc_result_t res_s2;
	logic        valid_s2;
	logic        advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	bcc_step u_step (
		.cur        (state_q),
		.status_n   (status_n_s1),
		.cmd_enable (cmd_enable_s1),
		.wait_n     (wait_n_s1),
		.addr_bit18 (addr_bit18_s1),
		.addr_bit19 (addr_bit19_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			status_n_s1   <= status_n;
			cmd_enable_s1 <= cmd_enable;
			wait_n_s1     <= wait_n;
			addr_bit18_s1 <= addr_bit18;
			addr_bit19_s1 <= addr_bit19;
		end
		if (advance)
			res_s2 <= res_nxt;
	end

	assign out_valid     = valid_s2;
	assign ale           = res_s2.pins[PB_ALE];
	assign den_n         = res_s2.pins[PB_DEN];
	assign dt_r          = res_s2.pins[PB_DTR];
	assign memr_n        = res_s2.pins[PB_MEMR];
	assign memw_n        = res_s2.pins[PB_MEMW];
	assign ior_n         = res_s2.pins[PB_IOR];
	assign iow_n         = res_s2.pins[PB_IOW];
	assign inta_n        = res_s2.pins[PB_INTA];
	assign data_xcvr_dir = res_s2.data_dir;
	assign ram_xcvr_dir  = res_s2.ram_dir;
	assign latch_release = res_s2.latch_release;
	assign hold_active   = res_s2.hold_active;

endmodule

>>> design/bcc_step.sv
module bcc_step
	import bcc_pkg::*;
(
	input  bcc_state_t  cur,
	input  logic [2:0]  status_n,
	input  logic        cmd_enable,
	input  logic        wait_n,
	input  logic        addr_bit18,
	input  logic        addr_bit19,
	output bcc_state_t  nxt,
	output bcc_result_t res
);

	ck_t  code;
	logic wait_act;
	logic ram_sel;
	logic active;
	logic done;
	logic pulse;
	logic [1:0] rc_dec;

	assign code     = ck_t'(~status_n);
	assign wait_act = ~wait_n;
	assign ram_sel  = ~addr_bit18 & ~addr_bit19;
	assign active   = (code != CK_PASSIVE) && (code != CK_HALT);
	assign rc_dec   = cur.recovery_count - 2'd1;

	always_comb begin
		nxt   = cur;
		done  = 1'b0;
		pulse = 1'b0;
		if (cur.recovery_count != 2'd0) begin
			if (!cmd_enable) begin
				done = 1'b1;
			end else begin
				nxt.recovery_count = rc_dec;
				if (rc_dec == 2'd2) begin
					nxt.dma_inhibited = 1'b0;
					if (cur.cycle_kind != CK_PASSIVE && cur.cycle_kind != CK_HALT) begin
						nxt.strobe_held = 1'b1;
						nxt.pins = cur.pins & ~strobe_bit(cur.cycle_kind);
						nxt.pins[PB_DEN] = 1'b0;
						nxt.data_dir = write_kind(cur.cycle_kind) ? DIR_OUT : DIR_IN;
						nxt.ram_dir  = ram_steer(cur.cycle_kind, ram_sel);
					end
					done = 1'b1;
				end else if (rc_dec == 2'd1) begin
					nxt.data_dir = write_kind(cur.cycle_kind) ? DIR_OUT : DIR_IN;
					nxt.ram_dir  = ram_steer(cur.cycle_kind, ram_sel);
					done = 1'b1;
				end
			end
		end
		if (!done) begin
			if (!cmd_enable && wait_act) begin
				if (!cur.dma_inhibited) begin
					nxt.pins = nxt.pins | PIN_STROBES;
					nxt.pins[PB_ALE] = 1'b0;
					nxt.pins[PB_DEN] = 1'b1;
					nxt.data_dir = DIR_OFF;
					nxt.ram_dir  = DIR_OFF;
					nxt.dma_inhibited = 1'b1;
				end
			end else if (cur.dma_inhibited) begin
				nxt.recovery_count = RECOVERY_STEPS;
				pulse = 1'b1;
			end else begin
				if (!cur.was_active && active) begin
					if (cur.strobe_held) begin
						nxt.pins = nxt.pins | PIN_STROBES;
						nxt.pins[PB_DEN] = 1'b1;
						nxt.data_dir = DIR_OFF;
						nxt.ram_dir  = DIR_OFF;
						nxt.strobe_held = 1'b0;
					end
					nxt.cycle_kind = code;
					nxt.pins[PB_ALE] = 1'b1;
					nxt.pins[PB_DTR] = write_kind(code);
				end else if (cur.was_active && active) begin
					nxt.pins[PB_ALE] = 1'b0;
					if (cmd_enable && !cur.strobe_held) begin
						nxt.pins = nxt.pins & ~strobe_bit(cur.cycle_kind);
						nxt.strobe_held = 1'b1;
					end
					nxt.pins[PB_DEN] = 1'b0;
					nxt.data_dir = write_kind(cur.cycle_kind) ? DIR_OUT : DIR_IN;
					nxt.ram_dir  = ram_steer(cur.cycle_kind, ram_sel);
				end else if (cur.was_active && !active) begin
					nxt.data_dir = write_kind(cur.cycle_kind) ? DIR_OUT : DIR_IN;
					nxt.ram_dir  = ram_steer(cur.cycle_kind, ram_sel);
				end
				nxt.was_active = active;
			end
		end
	end

	assign res.pins          = nxt.pins;
	assign res.data_dir      = nxt.data_dir;
	assign res.ram_dir       = nxt.ram_dir;
	assign res.latch_release = pulse;
	assign res.hold_active   = (nxt.recovery_count != 2'd0);

endmodule

>>> design/bcc_checker.sv
`include "bus_cycle_command_controller_unit_macros.svh"

module bcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       memr_n,
	input logic       memw_n,
	input logic       ior_n,
	input logic       iow_n,
	input logic       inta_n,
	input logic [1:0] data_xcvr_dir,
	input logic [1:0] ram_xcvr_dir,
	input logic       latch_release,
	input logic       hold_active
);

	`BCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(data_xcvr_dir))
	`BCC_ASSERT_NOW(a_release_hold, out_valid && latch_release, hold_active)
	`BCC_ASSERT_NOW(a_dir_codes, out_valid, data_xcvr_dir != 2'd3 && ram_xcvr_dir != 2'd3)
	`BCC_ASSERT_NOW(a_one_strobe, out_valid,
		$countones({memr_n, memw_n, ior_n, iow_n, inta_n}) >= 4)

endmodule

bind bus_cycle_command_controller_unit bcc_checker u_bcc_checker (.*);

>>> tb/bus_cycle_command_controller_unit_tb.sv
module bus_cycle_command_controller_unit_tb;
	import bcc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [2:0] status_n   = 3'd7;
	logic       cmd_enable = 1'b1;
	logic       wait_n     = 1'b1;
	logic       addr_bit18 = 1'b1;
	logic       addr_bit19 = 1'b1;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic       ale;
	logic       den_n;
	logic       dt_r;
	logic       memr_n;
	logic       memw_n;
	logic       ior_n;
	logic       iow_n;
	logic       inta_n;
	logic [1:0] data_xcvr_dir;
	logic [1:0] ram_xcvr_dir;
	logic       latch_release;
	logic       hold_active;

	ck_t        bus_kind        = CK_PASSIVE;
	logic       bus_was_active  = 1'b0;
	logic       bus_strobe_held = 1'b0;
	logic       bus_inhibited   = 1'b0;
	logic [1:0] recovery_left   = 2'd0;
	logic [7:0] pin_state       = PIN_RESET;
	logic [1:0] data_dir_state  = DIR_OFF;
	logic [1:0] ram_dir_state   = DIR_OFF;

	bcc_result_t pins_expected[$];
	int          fail_count = 0;
	int          items_sent = 0;
	bit          no_idle    = 1'b0;
	string       pin_name[8] = '{"ale", "den_n", "dt_r", "memr_n", "memw_n", "ior_n",
		"iow_n", "inta_n"};

	bus_cycle_command_controller_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.status_n      (status_n),
		.cmd_enable    (cmd_enable),
		.wait_n        (wait_n),
		.addr_bit18    (addr_bit18),
		.addr_bit19    (addr_bit19),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ale           (ale),
		.den_n         (den_n),
		.dt_r          (dt_r),
		.memr_n        (memr_n),
		.memw_n        (memw_n),
		.ior_n         (ior_n),
		.iow_n         (iow_n),
		.inta_n        (inta_n),
		.data_xcvr_dir (data_xcvr_dir),
		.ram_xcvr_dir  (ram_xcvr_dir),
		.latch_release (latch_release),
		.hold_active   (hold_active)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic void drive_strobe(ck_t k);
		case (k)
			CK_INTA:           pin_state[PB_INTA] = 1'b0;
			CK_IOR:            pin_state[PB_IOR]  = 1'b0;
			CK_IOW:            pin_state[PB_IOW]  = 1'b0;
			CK_FETCH, CK_MEMR: pin_state[PB_MEMR] = 1'b0;
			CK_MEMW:           pin_state[PB_MEMW] = 1'b0;
			default:           ;
		endcase
	endfunction

	function automatic void steer_xcvrs(logic ram_sel);
		data_dir_state = (bus_kind == CK_IOW || bus_kind == CK_MEMW) ? DIR_OUT : DIR_IN;
		ram_dir_state  = DIR_OFF;
		if (ram_sel) begin
			case (bus_kind)
				CK_FETCH, CK_MEMR: ram_dir_state = DIR_IN;
				CK_MEMW:           ram_dir_state = DIR_OUT;
				default:           ram_dir_state = DIR_OFF;
			endcase
		end
	endfunction

	function automatic bcc_result_t pin_snapshot(logic pulse);
		bcc_result_t r;
		r.pins          = pin_state;
		r.data_dir      = data_dir_state;
		r.ram_dir       = ram_dir_state;
		r.latch_release = pulse;
		r.hold_active   = (recovery_left != 2'd0);
		return r;
	endfunction

	function automatic bcc_result_t predict_bus_pins(logic [2:0] st, logic cen, logic wn,
		logic a18, logic a19);
		ck_t  code;
		logic ram_sel;
		logic now_active;
		code    = ck_t'(~st);
		ram_sel = !a18 && !a19;
		if (recovery_left != 2'd0) begin
			if (!cen)
				return pin_snapshot(1'b0);
			recovery_left = recovery_left - 2'd1;
			if (recovery_left == 2'd2) begin
				bus_inhibited = 1'b0;
				if (bus_kind != CK_PASSIVE && bus_kind != CK_HALT) begin
					bus_strobe_held = 1'b1;
					drive_strobe(bus_kind);
					pin_state[PB_DEN] = 1'b0;
					steer_xcvrs(ram_sel);
				end
				return pin_snapshot(1'b0);
			end
			if (recovery_left == 2'd1) begin
				steer_xcvrs(ram_sel);
				return pin_snapshot(1'b0);
			end
		end
		if (!cen && !wn) begin
			if (!bus_inhibited) begin
				pin_state          = pin_state | PIN_STROBES;
				pin_state[PB_ALE]  = 1'b0;
				pin_state[PB_DEN]  = 1'b1;
				data_dir_state     = DIR_OFF;
				ram_dir_state      = DIR_OFF;
				bus_inhibited      = 1'b1;
			end
			return pin_snapshot(1'b0);
		end
		if (bus_inhibited) begin
			recovery_left = RECOVERY_STEPS;
			return pin_snapshot(1'b1);
		end
		now_active = (code != CK_PASSIVE) && (code != CK_HALT);
		if (!bus_was_active && now_active) begin
			if (bus_strobe_held) begin
				pin_state         = pin_state | PIN_STROBES;
				pin_state[PB_DEN] = 1'b1;
				data_dir_state    = DIR_OFF;
				ram_dir_state     = DIR_OFF;
				bus_strobe_held   = 1'b0;
			end
			bus_kind          = code;
			pin_state[PB_ALE] = 1'b1;
			pin_state[PB_DTR] = (code == CK_IOW || code == CK_MEMW);
		end else if (bus_was_active && now_active) begin
			pin_state[PB_ALE] = 1'b0;
			if (cen && !bus_strobe_held) begin
				drive_strobe(bus_kind);
				bus_strobe_held = 1'b1;
			end
			pin_state[PB_DEN] = 1'b0;
			steer_xcvrs(ram_sel);
		end else if (bus_was_active && !now_active) begin
			steer_xcvrs(ram_sel);
		end
		bus_was_active = now_active;
		return pin_snapshot(1'b0);
	endfunction

	function automatic void compare_field(string name, logic [1:0] want, logic [1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_bus_pins();
		bcc_result_t want;
		logic [7:0]  got_pins;
		got_pins = {inta_n, iow_n, ior_n, memw_n, memr_n, dt_r, den_n, ale};
		if (pins_expected.size() == 0) begin
			$display("%0t: result with no item pending, pins %b", $time, got_pins);
			fail_count++;
			return;
		end
		want = pins_expected.pop_front();
		for (int i = 0; i < 8; i++)
			compare_field(pin_name[i], want.pins[i], got_pins[i]);
		compare_field("data_xcvr_dir", want.data_dir, data_xcvr_dir);
		compare_field("ram_xcvr_dir", want.ram_dir, ram_xcvr_dir);
		compare_field("latch_release", want.latch_release, latch_release);
		compare_field("hold_active", want.hold_active, hold_active);
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				check_bus_pins();
				stall = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(logic [2:0] st, logic cen, logic wn, logic a18, logic a19);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		status_n   <= st;
		cmd_enable <= cen;
		wait_n     <= wn;
		addr_bit18 <= a18;
		addr_bit19 <= a19;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pins_expected.push_back(predict_bus_pins(st, cen, wn, a18, a19));
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pins_expected.size() != 0) @(posedge clk);
	endtask

	task automatic test_bus_cycles();
		ck_t kinds[6] = '{CK_MEMW, CK_IOW, CK_MEMR, CK_IOR, CK_FETCH, CK_INTA};
		no_idle = 1'b0;
		foreach (kinds[i]) begin
			send_item(~kinds[i], 1'b1, 1'b1, i[0], i[0]);
			send_item(~kinds[i], 1'b1, 1'b1, i[0], i[0]);
			send_item(i == 5 ? ~CK_HALT : ~CK_PASSIVE, 1'b1, 1'b1, i[0], i[0]);
		end
		// hold the strobe of the cycle latched at T1 when status changes in T2
		send_item(~CK_IOR, 1'b1, 1'b1, 1'b0, 1'b0);
		send_item(~CK_MEMW, 1'b1, 1'b1, 1'b0, 1'b0);
	endtask

	task automatic test_dma_recovery();
		no_idle = 1'b1;
		send_item(~CK_PASSIVE, 1'b1, 1'b1, 1'b0, 1'b0);
		send_item(~CK_MEMR, 1'b1, 1'b1, 1'b0, 1'b0);
		send_item(~CK_MEMR, 1'b1, 1'b1, 1'b0, 1'b0);
		send_item(~CK_MEMR, 1'b0, 1'b0, 1'b0, 1'b0);
		send_item(~CK_MEMR, 1'b0, 1'b0, 1'b1, 1'b1);
		send_item(~CK_MEMR, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(~CK_MEMR, 1'b0, 1'b0, 1'b0, 1'b0);
		send_item(~CK_MEMR, 1'b1, 1'b1, 1'b0, 1'b0);
		send_item(~CK_MEMR, 1'b1, 1'b0, 1'b0, 1'b1);
		send_item(~CK_PASSIVE, 1'b1, 1'b1, 1'b0, 1'b0);
	endtask

	task automatic test_random_traffic();
		int  start;
		int  pick;
		ck_t k;
		start = items_sent;
		while (items_sent - start < 900) begin
			no_idle = ($urandom_range(0, 5) == 0);
			pick    = $urandom_range(0, 9);
			if (pick < 6) begin
				k = ck_t'($urandom_range(1, 7));
				if (k == CK_HALT)
					k = CK_MEMR;
				repeat ($urandom_range(0, 2))
					send_item($urandom_range(0, 1) ? ~CK_PASSIVE : ~CK_HALT, 1'b1,
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				repeat ($urandom_range(2, 4))
					send_item(~k, $urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0,
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				send_item($urandom_range(0, 3) ? ~CK_PASSIVE : ~CK_HALT,
					$urandom_range(0, 7) != 0, 1'b1, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else if (pick < 8) begin
				repeat ($urandom_range(1, 3))
					send_item(3'($urandom_range(0, 7)), 1'b0, 1'b0,
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b1,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				repeat ($urandom_range(3, 6))
					send_item(3'($urandom_range(0, 7)), $urandom_range(0, 2) != 0,
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 39) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_bus_cycles();
		wait_drained();
		test_dma_recovery();
		wait_drained();
		test_random_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pins_expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
